### design/assert_macros.svh
// Assertion macros used by the checker file of the camera pose block.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/flcpu_pkg.sv
// Shared types, constants and the sine table function of the camera pose block.
// Used by the controller, the datapath and the top level; depends on nothing.
package flcpu_pkg;

	localparam int SINE_ENTRIES_DEF = 1024;

	localparam logic [7:0] REG_LOOK_SENS  = 8'd0;
	localparam logic [7:0] REG_MOVE_SPEED = 8'd1;

	localparam logic [15:0] SENS_RST  = 16'd6554;
	localparam logic [15:0] SPEED_RST = 16'd640;

	localparam logic signed [24:0] YAW_RST  = -25'sd5898240;
	localparam logic signed [31:0] POSZ_RST = 32'sd196608;

	localparam logic signed [34:0] HALF_TURN_W = 35'sd11796480;
	localparam logic signed [25:0] HALF_TURN_A = 26'sd11796480;
	localparam logic [47:0]        HALF_TURN_U = 48'd11796480;
	localparam logic signed [25:0] FULL_TURN_A = 26'sd23592960;
	localparam logic signed [25:0] QUARTER_A   = 26'sd5898240;
	localparam logic signed [23:0] PITCH_MAX   = 24'sd5832704;

	localparam int              DIV_TURN     = 45;
	localparam logic [20:0]     RECIP45_IDX  = 21'd1491308;
	localparam logic [14:0]     RECIP45_WRAP = 15'd23302;
	localparam logic signed [15:0] WRAP_BIAS = 16'sd9000;
	localparam logic signed [15:0] WRAP_QOFF = 16'sd200;

	localparam int KEY_FWD   = 0;
	localparam int KEY_BACK  = 1;
	localparam int KEY_RIGHT = 2;
	localparam int KEY_LEFT  = 3;
	localparam int KEY_UP    = 4;
	localparam int KEY_DOWN  = 5;

	typedef enum logic [3:0] {
		OP_NONE, OP_ANGLE, OP_WRAP, OP_IDX_T, OP_IDX_Q, OP_IDX_FIX, OP_ROM, OP_STORE,
		OP_FX, OP_FZ, OP_SPEED, OP_MUL_LO, OP_MUL_HI, OP_POS
	} op_t;

	typedef enum logic [1:0] {
		LK_SIN_YAW, LK_COS_YAW, LK_SIN_PITCH, LK_COS_PITCH
	} lk_sel_t;

	typedef enum logic [2:0] {
		TM_FX, TM_FY, TM_FZ, TM_RX, TM_RZ
	} term_t;

	typedef struct packed {
		logic    load;
		op_t     op;
		lk_sel_t sel;
		term_t   term;
	} cmd_t;

	function automatic logic signed [15:0] sine_from_phase(input logic [63:0] p);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] tm;
		logic signed [63:0] s;
		q = (p >> 30) & 64'd3;
		r = p & 64'h3FFF_FFFF;
		if (q[0]) begin
			r = 64'h4000_0000 - r;
		end
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		tm = x;
		s = $signed(x);
		tm = ((tm * x2) >> 30) / 64'd6;
		s = s - $signed(tm);
		tm = ((tm * x2) >> 30) / 64'd20;
		s = s + $signed(tm);
		tm = ((tm * x2) >> 30) / 64'd42;
		s = s - $signed(tm);
		tm = ((tm * x2) >> 30) / 64'd72;
		s = s + $signed(tm);
		tm = ((tm * x2) >> 30) / 64'd110;
		s = s - $signed(tm);
		tm = ((tm * x2) >> 30) / 64'd156;
		s = s + $signed(tm);
		if (s < 0) begin
			s = 0;
		end
		if (s > 64'sh4000_0000) begin
			s = 64'sh4000_0000;
		end
		s = (s + 64'sd32768) >>> 16;
		return (q >= 64'd2) ? -s[15:0] : s[15:0];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
			input logic signed [33:0] d);
		logic signed [34:0] v;
		v = 35'(p) + 35'(d);
		if (v > 35'sh0_7FFF_FFFF) begin
			v = 35'sh0_7FFF_FFFF;
		end
		if (v < -35'sh0_8000_0000) begin
			v = -35'sh0_8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

### design/flcpu_ctrl.sv
// Sequencer of the camera pose block: steps the datapath through one tick.
// Depends on flcpu_pkg for the command types.
module flcpu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             out_free,
	output flcpu_pkg::cmd_t  cmd
);
	import flcpu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ANGLE, ST_WRAP, ST_IDX_T, ST_IDX_Q, ST_IDX_FIX, ST_ROM, ST_STORE,
		ST_FX, ST_FZ, ST_SPEED, ST_MUL_LO, ST_MUL_HI, ST_POS
	} state_t;

	state_t  state_q;
	lk_sel_t sel_q;
	term_t   term_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.sel = sel_q;
		cmd.term = term_q;
		case (state_q)
			ST_ANGLE:   cmd.op = OP_ANGLE;
			ST_WRAP:    cmd.op = OP_WRAP;
			ST_IDX_T:   cmd.op = OP_IDX_T;
			ST_IDX_Q:   cmd.op = OP_IDX_Q;
			ST_IDX_FIX: cmd.op = OP_IDX_FIX;
			ST_ROM:     cmd.op = OP_ROM;
			ST_STORE:   cmd.op = OP_STORE;
			ST_FX:      cmd.op = OP_FX;
			ST_FZ:      cmd.op = OP_FZ;
			ST_SPEED:   cmd.op = OP_SPEED;
			ST_MUL_LO:  cmd.op = OP_MUL_LO;
			ST_MUL_HI:  cmd.op = OP_MUL_HI;
			ST_POS:     cmd.op = out_free ? OP_POS : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= LK_SIN_YAW;
			term_q <= TM_FX;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ANGLE;
					end
				end
				ST_ANGLE:   state_q <= ST_WRAP;
				ST_WRAP: begin
					sel_q <= LK_SIN_YAW;
					state_q <= ST_IDX_T;
				end
				ST_IDX_T:   state_q <= ST_IDX_Q;
				ST_IDX_Q:   state_q <= ST_IDX_FIX;
				ST_IDX_FIX: state_q <= ST_ROM;
				ST_ROM:     state_q <= ST_STORE;
				ST_STORE: begin
					if (sel_q == LK_COS_PITCH) begin
						state_q <= ST_FX;
					end else begin
						sel_q <= lk_sel_t'(sel_q + 2'd1);
						state_q <= ST_IDX_T;
					end
				end
				ST_FX:      state_q <= ST_FZ;
				ST_FZ:      state_q <= ST_SPEED;
				ST_SPEED: begin
					term_q <= TM_FX;
					state_q <= ST_MUL_LO;
				end
				ST_MUL_LO:  state_q <= ST_MUL_HI;
				ST_MUL_HI: begin
					if (term_q == TM_RZ) begin
						state_q <= ST_POS;
					end else begin
						term_q <= term_t'(term_q + 3'd1);
						state_q <= ST_MUL_LO;
					end
				end
				ST_POS: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/flcpu_dpath.sv
// Datapath of the camera pose block: angle update, sine ROM lookups, front vector,
// movement products and saturating position update. Depends on flcpu_pkg.
module flcpu_dpath #(
	parameter int SINE_TABLE_ENTRIES = flcpu_pkg::SINE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  flcpu_pkg::cmd_t  cmd,
	output logic             out_free,
	input  logic [55:0]      in_tdata,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [143:0]     out_tdata
);
	import flcpu_pkg::*;

	localparam int IDXW = $clog2(SINE_TABLE_ENTRIES);
	localparam int TW = IDXW + 7;
	localparam int QW = IDXW + 1;

	logic signed [15:0] sine_rom [SINE_TABLE_ENTRIES];

	for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_rom
		localparam logic [63:0] PH = (64'(k) << 32) / 64'(SINE_TABLE_ENTRIES);
		assign sine_rom[k] = sine_from_phase(PH);
	end

	logic [15:0] sens_q, speed_q;
	logic signed [24:0] yaw_q;
	logic signed [23:0] pitch_q;
	logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [15:0] last_x_q, last_y_q;
	logic seen_q;
	logic out_valid_q;

	logic signed [15:0] cx_q, cy_q;
	logic look_q, boost_q;
	logic [5:0] keys_q;
	logic [15:0] dt_q;
	logic signed [34:0] yaw_sum_q;
	logic signed [35:0] pitch_sum_q;
	logic [TW-1:0] t_q;
	logic [QW-1:0] q0_q;
	logic [IDXW-1:0] idx_q;
	logic signed [15:0] rom_q, sy_q, cyw_q, sp_q, cp_q, fx_q, fz_q;
	logic [32:0] spd_q;
	logic signed [33:0] plo_q, mx_q, my_q, mz_q;
	logic [143:0] out_tdata_q;

	logic signed [16:0] dx, dy;
	logic signed [17:0] ndy;
	logic signed [33:0] prod_yaw;
	logic signed [34:0] prod_pitch;
	logic signed [15:0] s_w, q_w, hi_w;
	logic [14:0] u_w;
	logic [29:0] qp_w;
	logic [24:0] m_w;
	logic signed [25:0] yaw_new;
	logic signed [35:0] pitch_cl;
	logic signed [25:0] a_base, a_ang;
	logic [24:0] m_ang;
	logic [47:0] mn, qprod;
	logic [TW-1:0] qm, rem;
	logic [QW-1:0] qf;
	logic signed [31:0] pf;
	logic [16:0] speed2;
	logic signed [15:0] v_m;
	logic signed [32:0] ph;
	logic signed [50:0] full;
	logic signed [33:0] tm, up, delta, up_delta;
	logic [32:0] up_sum;
	logic kp, kn;
	logic signed [31:0] nx, ny, nz;

	always_comb begin
		dx = seen_q ? (17'(cx_q) - 17'(last_x_q)) : '0;
		dy = seen_q ? (17'(cy_q) - 17'(last_y_q)) : '0;
		ndy = -(18'(dy));
		prod_yaw = dx * $signed({1'b0, sens_q});
		prod_pitch = ndy * $signed({1'b0, sens_q});

		s_w = yaw_sum_q[34:19];
		u_w = 15'(s_w + WRAP_BIAS);
		qp_w = 30'(u_w) * 30'(RECIP45_WRAP);
		q_w = $signed(16'(qp_w[29:20])) - WRAP_QOFF;
		hi_w = s_w - q_w * 16'(DIV_TURN);
		m_w = {hi_w[5:0], yaw_sum_q[18:0]};
		yaw_new = $signed({1'b0, m_w}) - HALF_TURN_A;
		if (pitch_sum_q > 36'(PITCH_MAX)) begin
			pitch_cl = 36'(PITCH_MAX);
		end else if (pitch_sum_q < -36'(PITCH_MAX)) begin
			pitch_cl = -36'(PITCH_MAX);
		end else begin
			pitch_cl = pitch_sum_q;
		end

		a_base = (cmd.sel == LK_SIN_YAW || cmd.sel == LK_COS_YAW) ? 26'(yaw_q)
			: 26'(pitch_q);
		a_ang = (cmd.sel == LK_COS_YAW || cmd.sel == LK_COS_PITCH) ? a_base + QUARTER_A
			: a_base;
		m_ang = (a_ang < 0) ? 25'(a_ang + FULL_TURN_A) : 25'(a_ang);
		mn = 48'(m_ang) * 48'(SINE_TABLE_ENTRIES) + HALF_TURN_U;
		qprod = 48'(t_q) * 48'(RECIP45_IDX);
		qm = TW'(q0_q) * TW'(DIV_TURN);
		rem = t_q - qm;
		qf = q0_q + QW'(rem >= TW'(DIV_TURN));

		pf = (cmd.op == OP_FX) ? cyw_q * cp_q : sy_q * cp_q;
		speed2 = boost_q ? {speed_q, 1'b0} : {1'b0, speed_q};

		case (cmd.term)
			TM_FX:   v_m = fx_q;
			TM_FY:   v_m = sp_q;
			TM_FZ:   v_m = fz_q;
			TM_RX:   v_m = -sy_q;
			TM_RZ:   v_m = cyw_q;
			default: v_m = '0;
		endcase
		ph = v_m * $signed({1'b0, spd_q[32:17]});
		full = (51'(ph) <<< 17) + 51'(plo_q);
		tm = 34'((full + 51'sd2097152) >>> 22);
		if (cmd.term == TM_RX || cmd.term == TM_RZ) begin
			kp = keys_q[KEY_RIGHT];
			kn = keys_q[KEY_LEFT];
		end else begin
			kp = keys_q[KEY_FWD];
			kn = keys_q[KEY_BACK];
		end
		delta = (kp ? tm : '0) - (kn ? tm : '0);
		up_sum = spd_q + 33'd128;
		up = $signed({9'b0, up_sum[32:8]});
		up_delta = (keys_q[KEY_UP] ? up : '0) - (keys_q[KEY_DOWN] ? up : '0);

		nx = sat_add(pos_x_q, mx_q);
		ny = sat_add(pos_y_q, my_q);
		nz = sat_add(pos_z_q, mz_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= SENS_RST;
			speed_q <= SPEED_RST;
			yaw_q <= YAW_RST;
			pitch_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= POSZ_RST;
			last_x_q <= '0;
			last_y_q <= '0;
			seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_LOOK_SENS) begin
				sens_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_MOVE_SPEED) begin
				speed_q <= cfg_data;
			end
			if (cmd.op == OP_ANGLE) begin
				last_x_q <= cx_q;
				last_y_q <= cy_q;
				seen_q <= 1'b1;
			end
			if (cmd.op == OP_WRAP && look_q) begin
				yaw_q <= 25'(yaw_new);
				pitch_q <= 24'(pitch_cl);
			end
			if (cmd.op == OP_POS) begin
				pos_x_q <= nx;
				pos_y_q <= ny;
				pos_z_q <= nz;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= in_tdata[15:0];
			cy_q <= in_tdata[31:16];
			look_q <= in_tdata[32];
			boost_q <= in_tdata[33];
			keys_q <= in_tdata[39:34];
			dt_q <= in_tdata[55:40];
		end
		case (cmd.op)
			OP_ANGLE: begin
				yaw_sum_q <= 35'(yaw_q) + 35'(prod_yaw) + HALF_TURN_W;
				pitch_sum_q <= 36'(pitch_q) + 36'(prod_pitch);
				mx_q <= '0;
				my_q <= '0;
				mz_q <= '0;
			end
			OP_IDX_T:   t_q <= mn[19 +: TW];
			OP_IDX_Q:   q0_q <= qprod[26 +: QW];
			OP_IDX_FIX: idx_q <= (qf == QW'(SINE_TABLE_ENTRIES)) ? '0 : qf[IDXW-1:0];
			OP_ROM:     rom_q <= sine_rom[idx_q];
			OP_STORE: begin
				case (cmd.sel)
					LK_SIN_YAW:   sy_q <= rom_q;
					LK_COS_YAW:   cyw_q <= rom_q;
					LK_SIN_PITCH: sp_q <= rom_q;
					default:      cp_q <= rom_q;
				endcase
			end
			OP_FX:      fx_q <= 16'((pf + 32'sd8192) >>> 14);
			OP_FZ:      fz_q <= 16'((pf + 32'sd8192) >>> 14);
			OP_SPEED:   spd_q <= 33'(speed2) * 33'(dt_q);
			OP_MUL_LO: begin
				plo_q <= v_m * $signed({1'b0, spd_q[16:0]});
				if (cmd.term == TM_FX) begin
					my_q <= my_q + up_delta;
				end
			end
			OP_MUL_HI: begin
				case (cmd.term)
					TM_FX, TM_RX: mx_q <= mx_q + delta;
					TM_FY:        my_q <= my_q + delta;
					default:      mz_q <= mz_q + delta;
				endcase
			end
			OP_POS: begin
				out_tdata_q <= {nz, ny, nx, fz_q, sp_q, fx_q};
			end
			default: begin
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_tdata = out_tdata_q;

endmodule

### design/free_look_camera_pose_update.sv
// One tick in flight: the sequencer walks the shared index unit and ROM port four times and
// the shared 16x17 multiplier ten times and takes the next input transaction only once idle;
// it waits in the position step while the output register still holds an untaken result.
// A result waiting on the output register does not stop the next input transaction.
// Reset (arst_n, asynchronous, active low) restores pose, registers and cursor state.
module free_look_camera_pose_update #(
	parameter int SINE_TABLE_ENTRIES = flcpu_pkg::SINE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cursor_x, cursor_y, look_held, boost_held, move_keys, frame_time
	input  logic [55:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// front_x, front_y, front_z, place_x, place_y, place_z
	output logic [143:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import flcpu_pkg::*;

	cmd_t cmd;
	logic out_free;

	assign cfg_ready = 1'b1;

	flcpu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.cmd      (cmd)
	);

	flcpu_dpath #(
		.SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.out_free  (out_free),
		.in_tdata  (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tdata (m_axis_tdata)
	);

endmodule

### design/flcpu_checker.sv
// Port-level checks of the camera pose block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module flcpu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata
);

	`ASSERT_CLK_RST(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
	`ASSERT_CLK_RST(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while a tick is in progress")
	`ASSERT_CLK_RST(a_idle_on_result, clk, arst_n, $rose(m_axis_tvalid) |-> s_axis_tready, "sequencer not idle when result appears")
	`ASSERT_CLK_RST(a_front_range, clk, arst_n, m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) >= -16'sd16384 && $signed(m_axis_tdata[31:16]) <= 16'sd16384 && $signed(m_axis_tdata[15:0]) >= -16'sd16384 && $signed(m_axis_tdata[15:0]) <= 16'sd16384), "front component out of range")

endmodule

bind free_look_camera_pose_update flcpu_checker u_chk (.*);

### tb/free_look_camera_pose_update_tb.sv
// Self-checking testbench of the free-look camera pose block: frame ticks go in on the
// input stream and the expected pose of each tick is worked out here and compared.
// Depends on flcpu_pkg for the register indexes and on the free_look_camera_pose_update top.
module free_look_camera_pose_update_tb;
	import flcpu_pkg::*;

	localparam int        TABLE_N    = 1024;
	localparam longint    DEG        = 65536;
	localparam longint    TURN       = 360 * DEG;
	localparam longint    HALF       = 180 * DEG;
	localparam longint    QUARTER    = 90 * DEG;
	localparam longint    PITCH_LIM  = 89 * DEG;
	localparam logic [7:0] REG_SPARE = 8'd7;
	localparam int        SETTLE     = 60;
	localparam int        HOLD_OFF   = 300;
	localparam int        LIMIT      = 600000;

	typedef struct packed {
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fz;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} pose_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	pose_t        pose_queue[$];
	int           errors = 0;
	int           cycles = 0;
	bit           gaps_on = 1'b1;
	logic         stall_go = 1'b0;
	logic         stall_on = 1'b0;
	int           ready_idle = 0;

	logic signed [15:0] sine_rom[TABLE_N];
	longint       sens, speed, yaw, pitch;
	longint       pos_x, pos_y, pos_z, prev_cx, prev_cy;
	bit           seen;

	free_look_camera_pose_update dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [15:0] table_entry(int k);
		logic [63:0] p, q, r, x, x2, tm;
		longint s;
		p = (64'(k) << 32) / TABLE_N;
		q = (p >> 30) & 64'd3;
		r = p & 64'h3FFF_FFFF;
		if (q[0]) r = 64'h4000_0000 - r;
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		tm = x;
		s = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			tm = ((tm * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) s = s - longint'(tm);
			else s = s + longint'(tm);
		end
		if (s < 0) s = 0;
		if (s > (longint'(1) << 30)) s = longint'(1) << 30;
		s = (s + 32768) >>> 16;
		return (q >= 2) ? 16'(-s) : 16'(s);
	endfunction

	function automatic longint sine_deg(longint a);
		longint m, idx;
		m = a % TURN;
		if (m < 0) m += TURN;
		idx = (m * TABLE_N + HALF) / TURN;
		if (idx >= TABLE_N) idx -= TABLE_N;
		return longint'(sine_rom[idx]);
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic reset_pose();
		sens = SENS_RST;
		speed = SPEED_RST;
		yaw = -QUARTER;
		pitch = 0;
		pos_x = 0;
		pos_y = 0;
		pos_z = 3 * DEG;
		prev_cx = 0;
		prev_cy = 0;
		seen = 1'b0;
	endtask

	task automatic predict_pose(logic [55:0] d);
		longint cx, cy, dx, dy, y, sy, cyw, sp, cp, fx, fy, fz, spd, mx, my, mz;
		logic [5:0] keys;
		pose_t e;
		cx = longint'($signed(d[15:0]));
		cy = longint'($signed(d[31:16]));
		keys = d[39:34];
		dx = 0;
		dy = 0;
		mx = 0;
		my = 0;
		mz = 0;
		if (seen) begin
			dx = cx - prev_cx;
			dy = cy - prev_cy;
		end
		prev_cx = cx;
		prev_cy = cy;
		seen = 1'b1;
		if (d[32]) begin
			y = (yaw + dx * sens + HALF) % TURN;
			if (y < 0) y += TURN;
			yaw = y - HALF;
			pitch = pitch - dy * sens;
		end
		if (pitch > PITCH_LIM) pitch = PITCH_LIM;
		if (pitch < -PITCH_LIM) pitch = -PITCH_LIM;
		sy = sine_deg(yaw);
		cyw = sine_deg(yaw + QUARTER);
		sp = sine_deg(pitch);
		cp = sine_deg(pitch + QUARTER);
		fx = round_shift(cyw * cp, 14);
		fy = sp;
		fz = round_shift(sy * cp, 14);
		spd = speed * (d[33] ? 2 : 1) * longint'(d[55:40]);
		if (keys[KEY_FWD]) begin
			mx += round_shift(fx * spd, 22);
			my += round_shift(fy * spd, 22);
			mz += round_shift(fz * spd, 22);
		end
		if (keys[KEY_BACK]) begin
			mx -= round_shift(fx * spd, 22);
			my -= round_shift(fy * spd, 22);
			mz -= round_shift(fz * spd, 22);
		end
		if (keys[KEY_RIGHT]) begin
			mx += round_shift(-sy * spd, 22);
			mz += round_shift(cyw * spd, 22);
		end
		if (keys[KEY_LEFT]) begin
			mx -= round_shift(-sy * spd, 22);
			mz -= round_shift(cyw * spd, 22);
		end
		if (keys[KEY_UP]) my += round_shift(16384 * spd, 22);
		if (keys[KEY_DOWN]) my -= round_shift(16384 * spd, 22);
		pos_x = clamp32(pos_x + mx);
		pos_y = clamp32(pos_y + my);
		pos_z = clamp32(pos_z + mz);
		e.fx = 16'(fx);
		e.fy = 16'(fy);
		e.fz = 16'(fz);
		e.px = 32'(pos_x);
		e.py = 32'(pos_y);
		e.pz = 32'(pos_z);
		pose_queue.push_back(e);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		pose_t g, e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			g.fx = m_axis_tdata[15:0];
			g.fy = m_axis_tdata[31:16];
			g.fz = m_axis_tdata[47:32];
			g.px = m_axis_tdata[79:48];
			g.py = m_axis_tdata[111:80];
			g.pz = m_axis_tdata[143:112];
			if (pose_queue.size() == 0) begin
				report_mismatch("unexpected result", 32'(g.fx), 32'd0);
			end else begin
				e = pose_queue.pop_front();
				if (g.fx !== e.fx) report_mismatch("front_x", 32'(g.fx), 32'(e.fx));
				if (g.fy !== e.fy) report_mismatch("front_y", 32'(g.fy), 32'(e.fy));
				if (g.fz !== e.fz) report_mismatch("front_z", 32'(g.fz), 32'(e.fz));
				if (g.px !== e.px) report_mismatch("place_x", g.px, e.px);
				if (g.py !== e.py) report_mismatch("place_y", g.py, e.py);
				if (g.pz !== e.pz) report_mismatch("place_z", g.pz, e.pz);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_on) begin
			m_axis_tready <= 1'b0;
		end else if (!gaps_on) begin
			m_axis_tready <= 1'b1;
		end else if (ready_idle > 0) begin
			m_axis_tready <= 1'b0;
			ready_idle <= ready_idle - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			ready_idle <= $urandom_range(0, 3);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial forever begin
		@(posedge clk);
		if (stall_go) begin
			stall_go <= 1'b0;
			stall_on <= 1'b1;
			repeat (HOLD_OFF) @(posedge clk);
			stall_on <= 1'b0;
		end
	end

	task automatic send_tick(logic [15:0] cx, logic [15:0] cy, logic look, logic boost,
			logic [5:0] keys, logic [15:0] dt);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {dt, keys, boost, look, cy, cx};
		do @(posedge clk); while (!s_axis_tready);
		predict_pose({dt, keys, boost, look, cy, cx});
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pose_queue.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_LOOK_SENS) sens = val;
		else if (idx == REG_MOVE_SPEED) speed = val;
		@(posedge clk);
	endtask

	task automatic random_ticks(int count);
		logic [15:0] cx, cy;
		cx = 16'(prev_cx);
		cy = 16'(prev_cy);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				cx = 16'($urandom);
				cy = 16'($urandom);
			end else begin
				cx = cx + 16'($signed($urandom_range(0, 80)) - 40);
				cy = cy + 16'($signed($urandom_range(0, 80)) - 40);
			end
			send_tick(cx, cy, $urandom_range(0, 3) != 0, 1'($urandom), 6'($urandom),
				($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) :
					16'($urandom_range(0, 2200)));
		end
	endtask

	task automatic test_directed();
		// The first tick only records the cursor, even with look held.
		send_tick(16'sd500, -16'sd300, 1'b1, 1'b0, 6'd0, 16'd1092);
		send_tick(16'sd500, -16'sd300, 1'b0, 1'b0, 6'd1 << KEY_FWD, 16'd1092);
		for (int k = 0; k < 6; k++)
			send_tick(16'sd500, -16'sd300, 1'b0, 1'b0, 6'd1 << k, 16'd65535);
		send_tick(16'sd500, -16'sd300, 1'b0, 1'b1, 6'd63, 16'd65535);
		send_tick(16'sd500, -16'sd300, 1'b0, 1'b0, 6'b000011, 16'd4000);
		send_tick(16'sd500, -16'sd300, 1'b0, 1'b1, 6'b001100, 16'd0);
		// Full-scale cursor jumps drive pitch into both clamps and wrap yaw.
		send_tick(-16'sd32768, 16'sd32767, 1'b1, 1'b0, 6'd1, 16'd2000);
		send_tick(16'sd32767, -16'sd32768, 1'b1, 1'b0, 6'd1, 16'd2000);
		send_tick(-16'sd32768, 16'sd32767, 1'b1, 1'b1, 6'd4, 16'd2000);
		send_tick(16'sd32767, 16'sd32767, 1'b1, 1'b0, 6'd0, 16'd2000);
		send_tick(16'sd32767, 16'sd32767, 1'b0, 1'b0, 6'd16, 16'd65535);
		wait_drained();
	endtask

	task automatic test_register_sweep();
		logic [15:0] sens_set[5] = '{16'd0, 16'd65535, 16'd1, 16'd6554, 16'd300};
		logic [15:0] speed_set[5] = '{16'd65535, 16'd0, 16'd1, 16'd640, 16'd5000};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_LOOK_SENS, ph == 4 ? 16'($urandom) : sens_set[ph]);
			write_reg(REG_MOVE_SPEED, ph == 4 ? 16'($urandom) : speed_set[ph]);
			write_reg(REG_SPARE, 16'($urandom));
			random_ticks(ph == 0 ? 40 : 150);
			if (ph == 0) begin
				// Push the vertical axis into both saturation limits.
				for (int i = 0; i < 200; i++)
					send_tick(16'(prev_cx), 16'(prev_cy), 1'b0, 1'b1,
						(i < 70) ? (6'd1 << KEY_UP) : (6'd1 << KEY_DOWN), 16'd65535);
			end
			wait_drained();
		end
	endtask

	task automatic test_output_backpressure();
		stall_go <= 1'b1;
		random_ticks(40);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		random_ticks(20);
		wait_drained();
		random_ticks(20);
		wait_drained();
	endtask

	task automatic test_steady_stream();
		write_reg(REG_LOOK_SENS, SENS_RST);
		write_reg(REG_MOVE_SPEED, 16'd2000);
		random_ticks(180);
		gaps_on = 1'b0;
		random_ticks(150);
		wait_drained();
	endtask

	initial begin
		for (int k = 0; k < TABLE_N; k++) sine_rom[k] = table_entry(k);
		reset_pose();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_register_sweep();
		test_output_backpressure();
		test_drain_pause();
		test_steady_stream();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
